@@ src/krt_pkg.sv @@
// Shared types and constants for the keyed record table.
`default_nettype none

package krt_pkg;

    // Default table depth and the widest index the table may ever need.
    localparam int ENTRIES_DEFAULT = 16;
    localparam int ENTRIES_MAX     = 256;
    localparam int IDX_W           = $clog2(ENTRIES_MAX);

    // Field widths fixed by the interface.
    localparam int CMD_W    = 2;
    localparam int KEY_LO_W = 64;
    localparam int KEY_HI_W = 16;
    localparam int STAMP_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int SLOT_W   = 5;
    localparam int HIT_W    = 4;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Search token that walks the chain one cell per cycle.
    typedef struct packed {
        logic                valid;
        logic                match_found;
        logic [IDX_W-1:0]    match_idx;
        logic                empty_found;
        logic [IDX_W-1:0]    empty_idx;
        logic [STAMP_W-1:0]  oldest_stamp;
        logic [IDX_W-1:0]    oldest_idx;
        logic                rd_found;
        logic [KEY_LO_W-1:0] rd_key_low;
        logic [KEY_HI_W-1:0] rd_key_high;
        logic [STAMP_W-1:0]  rd_stamp;
        logic [COUNT_W-1:0]  rd_sent;
        logic [COUNT_W-1:0]  rd_answered;
    } scan_token_t;

    // Query held steady for the whole scan.
    typedef struct packed {
        logic [KEY_LO_W-1:0] key_low;
        logic [KEY_HI_W-1:0] key_high;
        logic [SLOT_W-1:0]   slot;
    } query_t;

    // Record write broadcast to every cell.
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic [KEY_LO_W-1:0] key_low;
        logic [KEY_HI_W-1:0] key_high;
        logic                stamp_en;
        logic [STAMP_W-1:0]  stamp;
        logic [COUNT_W-1:0]  sent;
        logic [COUNT_W-1:0]  answered;
    } rec_write_t;

endpackage

`default_nettype wire

@@ src/krt_cell.sv @@
// One table entry with its stage of the search chain.
`default_nettype none

module krt_cell
    import krt_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire scan_token_t tok_in,
    input  wire query_t      query,
    input  wire rec_write_t  wr,
    output scan_token_t      tok_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic [KEY_LO_W-1:0] key_low_reg;
    logic [KEY_HI_W-1:0] key_high_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [COUNT_W-1:0]  sent_reg;
    logic [COUNT_W-1:0]  answered_reg;
    scan_token_t         tok_reg;
    scan_token_t         tok_next;

    // Fold this entry into the running search results.
    always_comb begin
        tok_next = tok_in;
        if (!tok_in.match_found && key_low_reg == query.key_low
                && key_high_reg == query.key_high) begin
            tok_next.match_found = 1'b1;
            tok_next.match_idx   = MY_IDX;
        end
        if (!tok_in.empty_found && key_low_reg == '0 && key_high_reg == '0) begin
            tok_next.empty_found = 1'b1;
            tok_next.empty_idx   = MY_IDX;
        end
        if (stamp_reg < tok_in.oldest_stamp) begin
            tok_next.oldest_stamp = stamp_reg;
            tok_next.oldest_idx   = MY_IDX;
        end
        if (IDX_W'(query.slot) == MY_IDX) begin
            tok_next.rd_found    = 1'b1;
            tok_next.rd_key_low  = key_low_reg;
            tok_next.rd_key_high = key_high_reg;
            tok_next.rd_stamp    = stamp_reg;
            tok_next.rd_sent     = sent_reg;
            tok_next.rd_answered = answered_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            stamp_reg    <= '0;
            sent_reg     <= '0;
            answered_reg <= '0;
            tok_reg      <= '0;
        end else begin
            tok_reg <= tok_next;
            if (wr.en && wr.idx == MY_IDX) begin
                key_low_reg  <= wr.key_low;
                key_high_reg <= wr.key_high;
                sent_reg     <= wr.sent;
                answered_reg <= wr.answered;
                if (wr.stamp_en) begin
                    stamp_reg <= wr.stamp;
                end
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

@@ src/keyed_record_table_oldest_replace.sv @@
// Top level of the keyed record table with oldest-timestamp replacement.
//
//  Channel  Direction  Handshake          Word contents
//  s_       in         s_valid / s_ready  cmd, key, stamp, counts, slot
//  m_       out        m_valid / m_ready  status, hit index, stored record
//
// Each accepted word sends a search token through the chain of entry cells (one
// cell per cycle). The token is captured at the end of the chain, and the finish
// step then forms the result and, for an update, writes the chosen entry.
// The next word is accepted only after the result is loaded, so words never
// overlap.
// Reset clears every entry to all zero and empties the chain; no sweep is needed.
// Only one word is in work at a time. A finished result waits in the output
// register; a later result stalls in the finish step until that one is taken.
`default_nettype none

module keyed_record_table_oldest_replace
    import krt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [CMD_W-1:0]    s_cmd,
    input  wire logic [KEY_LO_W-1:0] s_key_low,
    input  wire logic [KEY_HI_W-1:0] s_key_high,
    input  wire logic [STAMP_W-1:0]  s_stamp,
    input  wire logic [COUNT_W-1:0]  s_sent_count,
    input  wire logic [COUNT_W-1:0]  s_answered_count,
    input  wire logic [SLOT_W-1:0]   s_slot,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_status,
    output logic [HIT_W-1:0]         m_hit_index,
    output logic [KEY_LO_W-1:0]      m_out_key_low,
    output logic [KEY_HI_W-1:0]      m_out_key_high,
    output logic [STAMP_W-1:0]       m_out_stamp,
    output logic [COUNT_W-1:0]       m_out_sent,
    output logic [COUNT_W-1:0]       m_out_answered
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t              state_reg;

    // Accepted word, held for the whole operation.
    logic [CMD_W-1:0]    cmd_reg;
    logic [KEY_LO_W-1:0] key_low_reg;
    logic [KEY_HI_W-1:0] key_high_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [COUNT_W-1:0]  sent_reg;
    logic [COUNT_W-1:0]  answered_reg;
    logic [SLOT_W-1:0]   slot_reg;

    scan_token_t         inject_reg;
    scan_token_t         pend_reg;
    scan_token_t         launch_token;

    // Output register.
    logic                m_valid_reg;
    logic                m_status_reg;
    logic [HIT_W-1:0]    m_hit_index_reg;
    logic [KEY_LO_W-1:0] m_key_low_reg;
    logic [KEY_HI_W-1:0] m_key_high_reg;
    logic [STAMP_W-1:0]  m_stamp_reg;
    logic [COUNT_W-1:0]  m_sent_reg;
    logic [COUNT_W-1:0]  m_answered_reg;

    scan_token_t         chain [0:ENTRIES];
    logic [ENTRIES:0]    tok_live;
    query_t              query;
    rec_write_t          wr;

    logic                out_free;
    logic                finish_fire;
    logic [IDX_W-1:0]    upd_idx;
    logic                res_status;
    logic [HIT_W-1:0]    res_hit;
    logic [KEY_LO_W-1:0] res_key_low;
    logic [KEY_HI_W-1:0] res_key_high;
    logic [STAMP_W-1:0]  res_stamp;
    logic [COUNT_W-1:0]  res_sent;
    logic [COUNT_W-1:0]  res_answered;

    assign s_ready     = (state_reg == ST_IDLE);
    assign out_free    = !m_valid_reg || m_ready;
    assign finish_fire = (state_reg == ST_FINISH) && out_free;

    assign query.key_low  = key_low_reg;
    assign query.key_high = key_high_reg;
    assign query.slot     = slot_reg;

    // A fresh token: nothing found yet, and the oldest search starts at the
    // largest stamp with entry zero as the fallback.
    always_comb begin
        launch_token              = '0;
        launch_token.valid        = 1'b1;
        launch_token.oldest_stamp = STAMP_MAX;
    end

    // The chain of entry cells. The token enters at cell zero, passes through
    // every cell in order and leaves from the last cell.
    assign chain[0]    = inject_reg;
    assign tok_live[0] = inject_reg.valid;

    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
        krt_cell #(
            .CELL_INDEX (gi)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (chain[gi]),
            .query   (query),
            .wr      (wr),
            .tok_out (chain[gi+1])
        );
        assign tok_live[gi+1] = chain[gi+1].valid;
    end

    // Result forming and the update write. The update slot is the first
    // key match, else the first empty entry, else the oldest entry.
    always_comb begin
        if (pend_reg.match_found) begin
            upd_idx = pend_reg.match_idx;
        end else if (pend_reg.empty_found) begin
            upd_idx = pend_reg.empty_idx;
        end else begin
            upd_idx = pend_reg.oldest_idx;
        end

        res_status   = 1'b1;
        res_hit      = '0;
        res_key_low  = '0;
        res_key_high = '0;
        res_stamp    = '0;
        res_sent     = '0;
        res_answered = '0;

        unique case (cmd_reg)
            CMD_LOOKUP: begin
                res_status = !pend_reg.match_found;
                if (pend_reg.match_found) begin
                    res_hit = pend_reg.match_idx[HIT_W-1:0];
                end
            end
            CMD_UPDATE: begin
                res_status = 1'b0;
                res_hit    = upd_idx[HIT_W-1:0];
            end
            CMD_READ: begin
                // Only a slot inside the table finds a cell.
                res_status = !pend_reg.rd_found;
                if (pend_reg.rd_found) begin
                    res_hit      = slot_reg[HIT_W-1:0];
                    res_key_low  = pend_reg.rd_key_low;
                    res_key_high = pend_reg.rd_key_high;
                    res_stamp    = pend_reg.rd_stamp;
                    res_sent     = pend_reg.rd_sent;
                    res_answered = pend_reg.rd_answered;
                end
            end
            default: begin
                // The unused command changes nothing and reports an error.
                res_status = 1'b1;
            end
        endcase

        wr.en       = finish_fire && (cmd_reg == CMD_UPDATE);
        wr.idx      = upd_idx;
        wr.key_low  = key_low_reg;
        wr.key_high = key_high_reg;
        wr.stamp_en = (sent_reg == answered_reg);
        wr.stamp    = stamp_reg;
        wr.sent     = sent_reg;
        wr.answered = answered_reg;
    end

    // Control sequence and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            inject_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // A token is launched only in the cycle a word is accepted.
            inject_reg <= (state_reg == ST_IDLE && s_valid) ? launch_token : '0;
            if (m_ready && !finish_fire) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg      <= s_cmd;
                        key_low_reg  <= s_key_low;
                        key_high_reg <= s_key_high;
                        stamp_reg    <= s_stamp;
                        sent_reg     <= s_sent_count;
                        answered_reg <= s_answered_count;
                        slot_reg     <= s_slot;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (chain[ENTRIES].valid) begin
                        pend_reg  <= chain[ENTRIES];
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_status_reg    <= res_status;
                        m_hit_index_reg <= res_hit;
                        m_key_low_reg   <= res_key_low;
                        m_key_high_reg  <= res_key_high;
                        m_stamp_reg     <= res_stamp;
                        m_sent_reg      <= res_sent;
                        m_answered_reg  <= res_answered;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_hit_index    = m_hit_index_reg;
    assign m_out_key_low  = m_key_low_reg;
    assign m_out_key_high = m_key_high_reg;
    assign m_out_stamp    = m_stamp_reg;
    assign m_out_sent     = m_sent_reg;
    assign m_out_answered = m_answered_reg;

    // At most one search token is ever in the chain.
    a_single_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_live))
        else $error("more than one search token in the chain");

    // While a new word may be accepted, the chain is empty.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (tok_live == '0))
        else $error("chain busy while accepting a word");

    // The token only leaves the chain during a scan.
    a_exit_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[ENTRIES].valid |-> (state_reg == ST_SCAN))
        else $error("token left the chain outside a scan");

    // Entries are written only for an update, and only when the result is loaded.
    a_write_update: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("entry write without a matching result");

endmodule

`default_nettype wire
